// ===== hw/rtl/rfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and codes for the rational accumulator ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int WIDE_BITS = 66;

   typedef enum logic [2:0] {
      OP_LOAD = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_COMBINE,
      S_GCD_START,
      S_GCD_DIV,
      S_GCD_STEP,
      S_QN_START,
      S_QN_DIV,
      S_QD_START,
      S_QD_DIV,
      S_CHECK,
      S_OUT
   } state_type;

   typedef struct packed {
      logic latch;
      logic mul;
      logic combine;
      logic div_start_gcd;
      logic div_start_qn;
      logic div_start_qd;
      logic div_step;
      logic gcd_swap;
      logic save_qn;
      logic save_qd;
      logic check;
      logic skip;
   } cmd_type;

   typedef struct packed {
      logic       early_done;
      logic       is_zero;
      logic       div_done;
      logic       gcd_b_zero;
   } stat_type;

endpackage

// ===== hw/rtl/rational_fraction_alu_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_top
// Signed rational accumulator with Euclidean GCD reduction.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one item (opcode, operand fraction); the
// rsp_ channel returns the accumulator after that item with a status.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. One item is worked on at a time; req_stall is high until the
// result has been taken.
// Steps per item: early exits (bad opcode, zero denominator, zero divisor)
// skip straight to the result. Otherwise multiply, combine, one divider pass
// per Euclid remainder step, two quotient passes and the check, with the passes
// all on one shared 66-bit restoring divider that retires one quotient bit per
// cycle. The result is offered in the last state of the item. The Euclid
// step count depends on the data.
// Reset clears the accumulator to 0/1 and returns to idle.
// While rsp_stall is high the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module rational_fraction_alu_top
   import rfa_pkg::*;
#(
   parameter int WORD_BITS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_operand_numerator,
   input  logic signed [31:0] req_operand_denominator,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_numerator,
   output logic [30:0]        rsp_result_denominator,
   output logic [1:0]         rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rfa_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_opcode              (req_opcode),
      .req_operand_numerator   (req_operand_numerator),
      .req_operand_denominator (req_operand_denominator),
      .rsp_result_numerator    (rsp_result_numerator),
      .rsp_result_denominator  (rsp_result_denominator),
      .rsp_status              (rsp_status)
   );

endmodule

// ===== hw/rtl/rfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: multiply, combine, Euclid loop, two quotient passes, check; early exits skip to the result.
// ----------------------------------------------------------------------------
module rfa_ctrl
   import rfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (stat.early_done) begin
               cmd.skip = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_COMBINE;
            end
         end
         S_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = S_GCD_START;
         end
         S_GCD_START: begin
            if (stat.is_zero || stat.gcd_b_zero) begin
               state_in = S_QN_START;
            end else begin
               cmd.div_start_gcd = 1'b1;
               state_in          = S_GCD_DIV;
            end
         end
         S_GCD_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_GCD_STEP;
            end
         end
         S_GCD_STEP: begin
            cmd.gcd_swap = 1'b1;
            state_in     = S_GCD_START;
         end
         S_QN_START: begin
            cmd.div_start_qn = 1'b1;
            state_in         = S_QN_DIV;
         end
         S_QN_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.save_qn = 1'b1;
               state_in    = S_QD_START;
            end
         end
         S_QD_START: begin
            cmd.div_start_qd = 1'b1;
            state_in         = S_QD_DIV;
         end
         S_QD_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.save_qd = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/rfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_datapath
// Accumulator, cross products, shared restoring divider and overflow check.
// ----------------------------------------------------------------------------
module rfa_datapath
   import rfa_pkg::*;
#(
   parameter int WORD_BITS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_operand_numerator,
   input  logic signed [31:0] req_operand_denominator,
   output logic signed [31:0] rsp_result_numerator,
   output logic [30:0]        rsp_result_denominator,
   output logic [1:0]         rsp_status
);

   localparam int W  = WORD_BITS;
   localparam int WB = WIDE_BITS;
   localparam int CW = $clog2(WB + 1);

   logic signed [W-1:0] acc_num_ff, acc_den_ff;
   logic [2:0]          op_ff;
   logic signed [W:0]   n2_ff, d2_ff;
   status_type          status_ff;
   logic                early_ff;

   logic signed [2*W+1:0] p1_ff, p2_ff, p3_ff;
   logic                  neg_ff;
   logic [WB-1:0]         mag_ff, den_ff, ga_ff, gb_ff;

   logic [WB-1:0] dq_ff, drem_ff, ddiv_ff;
   logic [CW-1:0] dcnt_ff;
   logic [WB-1:0] qn_ff, qd_ff;

   logic signed [W:0] n_ext, d_ext, n_pos, d_pos;
   logic [WB:0]       trial;
   logic [WB-1:0]     rem_shift;
   logic [WB-1:0]     q_next;

   logic signed [W:0]     acc_n_ext, acc_d_ext;
   logic signed [2*W+1:0] num_c, den_c;

   always_comb begin
      n_ext = (W + 1)'(signed'(req_operand_numerator[W-1:0]));
      d_ext = (W + 1)'(signed'(req_operand_denominator[W-1:0]));
      n_pos = d_ext[W] ? -n_ext : n_ext;
      d_pos = d_ext[W] ? -d_ext : d_ext;
      acc_n_ext = (W + 1)'(acc_num_ff);
      acc_d_ext = (W + 1)'(acc_den_ff);
   end

   always_comb begin
      rem_shift = {drem_ff[WB-2:0], dq_ff[WB-1]};
      trial     = {1'b0, rem_shift} - {1'b0, ddiv_ff};
      q_next    = {dq_ff[WB-2:0], ~trial[WB]};
   end

   always_comb begin
      num_c = p1_ff;
      den_c = p3_ff;
      unique case (op_ff)
         OP_LOAD: begin
            num_c = (2 * W + 2)'(n2_ff);
            den_c = (2 * W + 2)'(d2_ff);
         end
         OP_ADD:  num_c = p1_ff + p2_ff;
         OP_SUB:  num_c = p1_ff - p2_ff;
         OP_MUL:  num_c = p1_ff;
         default: begin
            num_c = n2_ff[W] ? -p1_ff : p1_ff;
            den_c = n2_ff[W] ? -p3_ff : p3_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= W'(1);
         status_ff  <= ST_OK;
         early_ff   <= 1'b0;
      end else begin
         if (cmd.latch) begin
            op_ff     <= req_opcode;
            n2_ff     <= n_pos;
            d2_ff     <= d_pos;
            status_ff <= ST_OK;
            early_ff  <= 1'b0;
            if (req_opcode > OP_DIV) begin
               early_ff <= 1'b1;
            end else if (d_ext == '0) begin
               early_ff  <= 1'b1;
               status_ff <= ST_ZERO_DEN;
            end else if (req_opcode == OP_DIV && n_ext == '0) begin
               early_ff  <= 1'b1;
               status_ff <= ST_DIV_ZERO;
            end
         end
         if (cmd.mul) begin
            unique case (op_ff)
               OP_MUL:  p1_ff <= acc_n_ext * n2_ff;
               default: p1_ff <= acc_n_ext * d2_ff;
            endcase
            p2_ff <= n2_ff * acc_d_ext;
            unique case (op_ff)
               OP_DIV:  p3_ff <= acc_d_ext * n2_ff;
               default: p3_ff <= acc_d_ext * d2_ff;
            endcase
         end
         if (cmd.combine) begin
            neg_ff <= num_c[2*W+1];
            mag_ff <= WB'(num_c[2*W+1] ? -num_c : num_c);
            den_ff <= WB'(den_c);
            ga_ff  <= WB'(num_c[2*W+1] ? -num_c : num_c);
            gb_ff  <= WB'(den_c);
         end
         if (cmd.div_start_gcd || cmd.div_start_qn || cmd.div_start_qd) begin
            drem_ff <= '0;
            dcnt_ff <= CW'(WB);
            if (cmd.div_start_gcd) begin
               dq_ff   <= ga_ff;
               ddiv_ff <= gb_ff;
            end else if (cmd.div_start_qn) begin
               dq_ff   <= mag_ff;
               ddiv_ff <= (mag_ff == '0) ? WB'(1) : ga_ff;
            end else begin
               dq_ff   <= den_ff;
               ddiv_ff <= (mag_ff == '0) ? den_ff : ga_ff;
            end
         end else if (cmd.div_step && dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - CW'(1);
            if (!trial[WB]) begin
               drem_ff <= trial[WB-1:0];
            end else begin
               drem_ff <= rem_shift;
            end
            dq_ff <= q_next;
         end
         if (cmd.gcd_swap) begin
            ga_ff <= gb_ff;
            gb_ff <= drem_ff;
         end
         // last quotient bit lands on the same edge
         if (cmd.save_qn) begin
            qn_ff <= q_next;
         end
         if (cmd.save_qd) begin
            qd_ff <= q_next;
         end
         if (cmd.check) begin
            if (qn_ff > WB'(1) << (W - 1) || qd_ff > (WB'(1) << (W - 1)) - WB'(1)
                || (!neg_ff && qn_ff > (WB'(1) << (W - 1)) - WB'(1))) begin
               status_ff <= ST_OVERFLOW;
            end else begin
               acc_num_ff <= neg_ff ? -W'(qn_ff) : W'(qn_ff);
               acc_den_ff <= W'(qd_ff);
            end
         end
      end
   end

   always_comb begin
      stat.early_done = early_ff;
      stat.is_zero    = (mag_ff == '0);
      stat.gcd_b_zero = (gb_ff == '0);
      stat.div_done   = (dcnt_ff == CW'(1));
   end

   assign rsp_result_numerator   = 32'(acc_num_ff);
   assign rsp_result_denominator = 31'(acc_den_ff);
   assign rsp_status             = status_ff;

endmodule
